[design/imufrx_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the IMU frame receiver.
// Used by imufrx_scale and imu_frame_receiver_crc16; depends on nothing else.
package imufrx_pkg;

    // Field widths
    localparam int RX_BYTE_W  = 8;
    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int SCALED_W   = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Default frame length in payload bytes (check value included)
    localparam int PAYLOAD_LEN_DEF = 35;

    // CRC-16, MSB first, no final xor
    localparam logic [15:0] CRC_SEED = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Register reset values
    localparam logic [GAIN_W-1:0]    GAIN_RESET          = 24'h01_0000;
    localparam logic [RX_BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h4C;
    localparam logic [RX_BYTE_W-1:0] HEADER_SECOND_RESET = 8'h53;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd2;

    // Receiver phase: hunt first header byte, expect second, collect payload
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_SECOND  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    // One finished frame on its way to the scaling stage
    typedef struct packed {
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
        logic [RAW_W-1:0] z_raw;
        logic             crc_ok;
    } frame_t;

    // Advance the CRC by one byte: eight shift-and-xor steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [RX_BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[design/imufrx_scale.sv]
// Output stage of the IMU frame receiver: gain multiply and result register.
// Depends on imufrx_pkg.
module imufrx_scale (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [imufrx_pkg::GAIN_W-1:0]       gain,
    input  logic                                in_valid,
    input  imufrx_pkg::frame_t                  in_frame,
    output logic                                in_ready,
    input  logic                                out_ready,
    output logic                                out_valid,
    output imufrx_pkg::frame_t                  out_frame,
    output logic [imufrx_pkg::SCALED_W-1:0]     x_scaled,
    output logic [imufrx_pkg::SCALED_W-1:0]     y_scaled,
    output logic [imufrx_pkg::SCALED_W-1:0]     z_scaled
);
    import imufrx_pkg::*;

    localparam int PROD_W = RAW_W + GAIN_W;

    logic               valid_reg;
    frame_t             frame_reg;
    logic [SCALED_W-1:0] x_reg, y_reg, z_reg;
    logic [PROD_W-1:0]  prod_x, prod_y, prod_z;

    // Take a new transaction when empty or when the current one leaves
    assign in_ready = !valid_reg || out_ready;

    // Scale by gain in units of 2^-16; a 16-bit word times a 24-bit gain
    // shifted right by 16 always fits in 24 bits, so no clamp is needed
    assign prod_x = PROD_W'(in_frame.x_raw) * PROD_W'(gain);
    assign prod_y = PROD_W'(in_frame.y_raw) * PROD_W'(gain);
    assign prod_z = PROD_W'(in_frame.z_raw) * PROD_W'(gain);

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            frame_reg <= in_frame;
            x_reg     <= prod_x[PROD_W-1:16];
            y_reg     <= prod_y[PROD_W-1:16];
            z_reg     <= prod_z[PROD_W-1:16];
        end
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;
    assign x_scaled  = x_reg;
    assign y_scaled  = y_reg;
    assign z_scaled  = z_reg;

endmodule

[design/imu_frame_receiver_crc16.sv]
// Top level of the IMU frame receiver: header search, payload capture, CRC-16 check.
// Depends on imufrx_pkg and imufrx_scale.
//
//   port group | direction | carries
//   s_*        | in        | one received byte per transaction
//   m_*        | out       | one decoded frame per transaction
//   cfg_*      | in        | register writes (gain, header bytes)
//
// One byte is taken every cycle while the output side keeps up. After the edge
// that takes a frame's last byte, the frame register loads, and then the gain
// multiply is written into the output register, which raises m_tvalid. Reset
// is synchronous on aresetn and returns the header search to its start. When
// m_tready is low, each stage holds and s_tready drops once all stages are
// full.
module imu_frame_receiver_crc16 #(
    parameter int PAYLOAD_LEN = imufrx_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // s_tdata: rx_byte[7:0]
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,
    // m_tdata: accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32],
    //          accel_x_scaled[71:48], accel_y_scaled[95:72], accel_z_scaled[119:96]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [119:0]                           m_tdata,
    // m_tuser: crc_ok[0]
    output logic                                   m_tuser,
    input  logic                                   cfg_we,
    input  logic [imufrx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [imufrx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import imufrx_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_LEN);
    localparam logic [CNT_W-1:0] CHK_HI_IDX = CNT_W'(PAYLOAD_LEN - 2);
    localparam logic [CNT_W-1:0] AXIS_END   = CNT_W'(6);

    // Configuration registers
    logic [GAIN_W-1:0]    gain_reg;
    logic [RX_BYTE_W-1:0] hdr1_reg, hdr2_reg;

    // Input register
    logic                 byte_valid_reg;
    logic [RX_BYTE_W-1:0] byte_reg;

    // Frame state
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           chk_hi_reg, chk_hi_next;
    logic [RAW_W-1:0]     axis_reg [3];
    logic [RAW_W-1:0]     axis_next [3];

    // Frame result register
    logic                 res_valid_reg;
    frame_t               res_reg;
    logic                 res_ready;
    logic                 byte_fire;
    logic                 emit;

    // Output stage signals
    logic                 scale_ready;
    frame_t               out_frame;
    logic [SCALED_W-1:0]  x_scaled, y_scaled, z_scaled;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            hdr1_reg <= HEADER_FIRST_RESET;
            hdr2_reg <= HEADER_SECOND_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ACCEL_GAIN:    gain_reg <= cfg_wdata;
                CFG_HEADER_FIRST:  hdr1_reg <= cfg_wdata[RX_BYTE_W-1:0];
                CFG_HEADER_SECOND: hdr2_reg <= cfg_wdata[RX_BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Ready chain back from the output register
    assign res_ready = !res_valid_reg || scale_ready;
    assign byte_fire = byte_valid_reg && res_ready;
    assign s_tready  = !byte_valid_reg || res_ready;

    // Capture the incoming byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_tready) begin
            byte_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

    // Advance the header search and payload capture by one byte
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        chk_hi_next = chk_hi_reg;
        axis_next   = axis_reg;
        emit        = 1'b0;
        if (byte_fire) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    if (byte_reg == hdr2_reg) begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                        crc_next   = CRC_SEED;
                    end else if (byte_reg == hdr1_reg) begin
                        phase_next = PH_SECOND;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (count_reg < CHK_HI_IDX) begin
                        // CRC-covered byte; the first six also fill the axis words
                        crc_next = crc_byte(crc_reg, byte_reg);
                        if (count_reg < AXIS_END) begin
                            if (!count_reg[0]) begin
                                axis_next[count_reg[2:1]][15:8] = byte_reg;
                            end else begin
                                axis_next[count_reg[2:1]][7:0] = byte_reg;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end else if (count_reg == CHK_HI_IDX) begin
                        chk_hi_next = byte_reg;
                        count_next  = count_reg + CNT_W'(1);
                    end else begin
                        // Last byte: close the frame and restart the search
                        emit       = 1'b1;
                        phase_next = PH_HUNT;
                        count_next = '0;
                        crc_next   = CRC_SEED;
                    end
                end
                default: begin
                    phase_next = (byte_reg == hdr1_reg) ? PH_SECOND : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            crc_reg   <= CRC_SEED;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_hi_reg <= chk_hi_next;
        axis_reg   <= axis_next;
    end

    // Hold the finished frame for the scaling stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg.x_raw  <= axis_reg[0];
            res_reg.y_raw  <= axis_reg[1];
            res_reg.z_raw  <= axis_reg[2];
            res_reg.crc_ok <= (crc_reg == {chk_hi_reg, byte_reg});
        end
    end

    // Gain multiply and output register
    imufrx_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .in_valid  (res_valid_reg),
        .in_frame  (res_reg),
        .in_ready  (scale_ready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_frame (out_frame),
        .x_scaled  (x_scaled),
        .y_scaled  (y_scaled),
        .z_scaled  (z_scaled)
    );

    assign m_tdata = {z_scaled, y_scaled, x_scaled,
                      out_frame.z_raw, out_frame.y_raw, out_frame.x_raw};
    assign m_tuser = out_frame.crc_ok;

endmodule
